// ===== hw/rtl/tts_pkg.sv =====
`default_nettype none

package tts_pkg;

	// Fixed port field widths
	localparam int FRAME_BITS  = 2;
	localparam int COORD_BITS  = 6;
	localparam int SAMPLE_IN_W = 8;
	localparam int RESULT_BITS = 8;

	// Filter weights
	localparam int CENTRE_WEIGHT = 6;
	localparam int WEIGHT_TOTAL  = 14;

	// Microprogram step addresses
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd0;
	localparam logic [STEP_W-1:0] STEP_WRITE = 4'd1;
	localparam logic [STEP_W-1:0] STEP_READ  = 4'd2;
	localparam logic [STEP_W-1:0] STEP_LAST  = 4'd13;

	typedef enum logic [1:0] {
		OFS_ZERO,
		OFS_MINUS,
		OFS_PLUS
	} ofs_t;

	typedef enum logic [1:0] {
		SEQ_NEXT,
		SEQ_HOME,
		SEQ_DISPATCH
	} seq_t;

	typedef struct packed {
		ofs_t              dx;
		ofs_t              dy;
		logic              write;
		logic              acc_clr;
		logic              acc_add;
		logic              centre;
		logic              mul;
		logic              emit;
		seq_t              seq;
		logic [STEP_W-1:0] target;
	} uop_t;

	typedef struct packed {
		logic accept;
		uop_t uop;
	} dp_ctrl_t;

	localparam uop_t UOP_NOP = '{
		dx:      OFS_ZERO,
		dy:      OFS_ZERO,
		write:   1'b0,
		acc_clr: 1'b0,
		acc_add: 1'b0,
		centre:  1'b0,
		mul:     1'b0,
		emit:    1'b0,
		seq:     SEQ_NEXT,
		target:  STEP_IDLE
	};

	// Control store. A fetch issued in one step lands in the accumulator in the next.
	function automatic uop_t ucode(input logic [STEP_W-1:0] step);
		uop_t u;
		u = UOP_NOP;
		case (step)
			STEP_IDLE: begin
				u.seq    = SEQ_DISPATCH;
				u.target = STEP_READ;
			end
			STEP_WRITE: begin
				u.write = 1'b1;
				u.seq   = SEQ_HOME;
			end
			STEP_READ: begin
				u.dx      = OFS_MINUS;
				u.dy      = OFS_MINUS;
				u.acc_clr = 1'b1;
			end
			4'd3: begin
				u.dy      = OFS_MINUS;
				u.acc_add = 1'b1;
			end
			4'd4: begin
				u.dx      = OFS_PLUS;
				u.dy      = OFS_MINUS;
				u.acc_add = 1'b1;
			end
			4'd5: begin
				u.dx      = OFS_MINUS;
				u.acc_add = 1'b1;
			end
			4'd6: begin
				u.acc_add = 1'b1;
			end
			4'd7: begin
				u.dx      = OFS_PLUS;
				u.acc_add = 1'b1;
				u.centre  = 1'b1;
			end
			4'd8: begin
				u.dx      = OFS_MINUS;
				u.dy      = OFS_PLUS;
				u.acc_add = 1'b1;
			end
			4'd9: begin
				u.dy      = OFS_PLUS;
				u.acc_add = 1'b1;
			end
			4'd10: begin
				u.dx      = OFS_PLUS;
				u.dy      = OFS_PLUS;
				u.acc_add = 1'b1;
			end
			4'd11: begin
				u.acc_add = 1'b1;
			end
			4'd12: begin
				u.mul = 1'b1;
			end
			STEP_LAST: begin
				u.emit = 1'b1;
				u.seq  = SEQ_HOME;
			end
			default: begin
				u.seq = SEQ_HOME;
			end
		endcase
		return u;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tts_ram.sv =====
`default_nettype none

module tts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16384
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tts_sequencer.sv =====
`default_nettype none

module tts_sequencer
	import tts_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic action,
	output logic      busy,
	output dp_ctrl_t  ctrl
);

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_d;
	uop_t              uop;

	assign uop  = ucode(step_q);
	assign busy = (step_q != STEP_IDLE);

	always_comb begin
		ctrl.accept = start & ~busy;
		ctrl.uop    = uop;
	end

	always_comb begin
		step_d = step_q + STEP_W'(1);
		case (uop.seq)
			SEQ_NEXT:     step_d = step_q + STEP_W'(1);
			SEQ_HOME:     step_d = STEP_IDLE;
			SEQ_DISPATCH: begin
				// hold until a word arrives, then branch on its action
				if (!start) begin
					step_d = step_q;
				end else if (action) begin
					step_d = uop.target;
				end else begin
					step_d = step_q + STEP_W'(1);
				end
			end
			default:      step_d = STEP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tts_datapath.sv =====
`default_nettype none

module tts_datapath
	import tts_pkg::*;
#(
	parameter int SIDE        = 64,
	parameter int FRAMES      = 4,
	parameter int SAMPLE_BITS = 8,
	parameter int AW          = 14
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire dp_ctrl_t               ctrl,
	input  wire logic [FRAME_BITS-1:0]  frame_index,
	input  wire logic [COORD_BITS-1:0]  column,
	input  wire logic [COORD_BITS-1:0]  row,
	input  wire logic [SAMPLE_IN_W-1:0] sample,
	output logic      [AW-1:0]          mem_addr,
	output logic                        mem_we,
	output logic      [SAMPLE_BITS-1:0] mem_wdata,
	input  wire logic [SAMPLE_BITS-1:0] mem_rdata,
	output logic                        done,
	output logic      [RESULT_BITS-1:0] smoothed
);

	localparam int CW   = $clog2(SIDE);
	localparam int SW   = SAMPLE_BITS + 4;
	localparam int HW   = SW - 1;
	localparam int HALF = WEIGHT_TOTAL / 2;
	localparam int RECIP_INT = (2 ** HW) / HALF;

	logic [FRAME_BITS-1:0]  frame_q;
	logic                   frame_ok_q;
	logic [CW-1:0]          col_q;
	logic [CW-1:0]          row_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [SW-1:0]          acc_q;
	logic [2*HW-1:0]        prod_q;
	logic                   done_q;
	logic [RESULT_BITS-1:0] smoothed_q;

	logic [CW-1:0]          x;
	logic [CW-1:0]          y;
	logic [SAMPLE_BITS-1:0] tap_data;
	logic [SW-1:0]          addend;
	logic [HW-1:0]          half_sum;
	logic [HW-1:0]          recip;
	logic [HW-1:0]          q0;
	logic [HW+2:0]          rem;
	logic [HW-1:0]          quot;

	function automatic logic [CW-1:0] wrap(input logic [CW-1:0] c, input ofs_t o);
		logic [CW-1:0] r;
		case (o)
			OFS_MINUS: r = c - CW'(1);
			OFS_PLUS:  r = c + CW'(1);
			default:   r = c;
		endcase
		return r;
	endfunction

	// capture the word's fields
	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			frame_q    <= frame_index;
			frame_ok_q <= (32'(frame_index) < FRAMES);
			col_q      <= CW'(column);
			row_q      <= CW'(row);
			sample_q   <= SAMPLE_BITS'(sample);
		end
	end

	assign x         = wrap(col_q, ctrl.uop.dx);
	assign y         = wrap(row_q, ctrl.uop.dy);
	assign mem_addr  = AW'({frame_q, y, x});
	assign mem_we    = ctrl.uop.write & frame_ok_q;
	assign mem_wdata = sample_q;

	// drop data of a frame that does not exist
	assign tap_data = frame_ok_q ? mem_rdata : '0;
	assign addend   = ctrl.uop.centre ? SW'(tap_data) * SW'(CENTRE_WEIGHT) : SW'(tap_data);

	always_ff @(posedge clk) begin
		if (ctrl.uop.acc_clr) begin
			acc_q <= '0;
		end else if (ctrl.uop.acc_add) begin
			acc_q <= acc_q + addend;
		end
	end

	// sum / 14 = (sum >> 1) / 7: reciprocal estimate, low by at most one
	assign half_sum = acc_q[SW-1:1];
	assign recip    = HW'(RECIP_INT);

	always_ff @(posedge clk) begin
		if (ctrl.uop.mul) begin
			prod_q <= (2*HW)'(half_sum) * (2*HW)'(recip);
		end
	end

	assign q0   = prod_q[2*HW-1:HW];
	assign rem  = (HW+3)'(half_sum) - ({q0, 3'b000} - (HW+3)'(q0));
	assign quot = q0 + HW'(rem >= (HW+3)'(HALF));

	always_ff @(posedge clk) begin
		if (ctrl.uop.emit) begin
			smoothed_q <= RESULT_BITS'(quot);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl.uop.emit;
		end
	end

	assign done     = done_q;
	assign smoothed = smoothed_q;

endmodule

`default_nettype wire

// ===== hw/rtl/toroidal_tile_smoothing_filter.sv =====
`default_nettype none

// Weighted 3x3 smoothing over FRAMES toroidal tiles of SIDE x SIDE samples.
// Present a word with start high while busy is low; it is taken at that
// clock edge. action 0 stores sample at (frame_index, column, row) and keeps
// busy high for one cycle after acceptance. action 1 reads the smoothed value
// there: the eight wrapped neighbors at weight 1 plus the center at weight 6,
// summed and divided by 14, truncated. The result appears on smoothed with
// done high for exactly one cycle, the cycle that ends at the clock edge at
// which done drops; the receiver cannot stall, so capture it at that edge. A
// read runs in steps: nine fetches from the single-port tile memory at one per
// cycle, an add of the last fetch, the reciprocal multiply, the correction
// step of the divide by 14 and an idle step in which the next word can be
// taken.
// The tile memory has no clearing pass and holds garbage until written: read
// only neighborhoods whose nine entries were all written. A frame_index of
// FRAMES or more drops writes and reads back zero.

module toroidal_tile_smoothing_filter
	import tts_pkg::*;
#(
	parameter int SIDE        = 64,
	parameter int FRAMES      = 4,
	parameter int SAMPLE_BITS = 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic                   action,
	input  wire logic [FRAME_BITS-1:0]  frame_index,
	input  wire logic [COORD_BITS-1:0]  column,
	input  wire logic [COORD_BITS-1:0]  row,
	input  wire logic [SAMPLE_IN_W-1:0] sample,
	output logic                        done,
	output logic      [RESULT_BITS-1:0] smoothed
);

	// One entry per sample of every tile, addressed {frame, row, column}
	localparam int DEPTH = FRAMES * SIDE * SIDE;
	localparam int AW    = $clog2(DEPTH);

	dp_ctrl_t               ctrl;
	logic [AW-1:0]          mem_addr;
	logic                   mem_we;
	logic [SAMPLE_BITS-1:0] mem_wdata;
	logic [SAMPLE_BITS-1:0] mem_rdata;

	// Step counter and control store
	tts_sequencer u_sequencer (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	// Address generation, accumulator and divide by 14
	tts_datapath #(
		.SIDE        (SIDE),
		.FRAMES      (FRAMES),
		.SAMPLE_BITS (SAMPLE_BITS),
		.AW          (AW)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.frame_index (frame_index),
		.column      (column),
		.row         (row),
		.sample      (sample),
		.mem_addr    (mem_addr),
		.mem_we      (mem_we),
		.mem_wdata   (mem_wdata),
		.mem_rdata   (mem_rdata),
		.done        (done),
		.smoothed    (smoothed)
	);

	// Tile store, single port with registered read
	tts_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (DEPTH)
	) u_tile_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/tts_checker.sv =====
`default_nettype none

module tts_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic action,
	input wire logic done
);

	// an accepted read is followed by its done strobe
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action) |-> ##13 done)
		else $error("read result missing at expected latency");

	// a write holds busy for exactly one cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !action) |=> busy ##1 !busy)
		else $error("write busy window wrong");

	// results are single-cycle strobes
	assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	// a result shows only once the block is free again
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

endmodule

bind toroidal_tile_smoothing_filter tts_checker u_checker (.*);

`default_nettype wire

// ===== sim/tb_toroidal_tile_smoothing_filter.sv =====
`timescale 1ns / 100ps

module tb_toroidal_tile_smoothing_filter;
	import tts_pkg::*;

	// Action codes on the action port
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_READ  = 1'b1;

	localparam int TILE_SIDE   = 64;
	localparam int STORE_CELLS = 4 * TILE_SIDE * TILE_SIDE;
	localparam int RANDOM_OPS  = 850;
	localparam int PHASE_LEN   = 110;
	localparam int SETTLE_CYC  = 20;

	// One word for the block, plus how the driver presents it.
	typedef struct {
		logic                   act;
		logic [FRAME_BITS-1:0]  frame;
		logic [COORD_BITS-1:0]  x;
		logic [COORD_BITS-1:0]  y;
		logic [SAMPLE_IN_W-1:0] value;
		int unsigned            gap_pct;    // chance of an idle cycle before launch
		bit                     wait_drain; // launch only once all reads have returned
	} tile_op_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   action = ACT_WRITE;
	logic [FRAME_BITS-1:0]  frame_index = '0;
	logic [COORD_BITS-1:0]  column = '0;
	logic [COORD_BITS-1:0]  row = '0;
	logic [SAMPLE_IN_W-1:0] sample = '0;
	logic                   busy;
	logic                   done;
	logic [RESULT_BITS-1:0] smoothed;

	tile_op_t         pending_ops[$];
	logic [7:0]       expected_smoothed[$];
	logic [13:0]      ready_centers[$];      // {frame, y, x} whose 3x3 patch is written
	logic [7:0]       tile_model[0:STORE_CELLS-1];
	bit               gen_filled[0:STORE_CELLS-1];
	bit               hold_for_drain;
	int unsigned      mismatch_count;

	toroidal_tile_smoothing_filter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.frame_index(frame_index),
		.column     (column),
		.row        (row),
		.sample     (sample),
		.done       (done),
		.smoothed   (smoothed)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Smoothed value at (f, x, y) from the shadow tiles. Neighbor coordinates
	// wrap because they stay 6 bits wide. With four frames on a 2-bit index,
	// every frame exists, so the out-of-range frame case cannot be reached.
	function automatic logic [7:0] smoothed_at(input logic [FRAME_BITS-1:0] f,
			input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
		logic [11:0]           acc;
		logic [COORD_BITS-1:0] nx;
		logic [COORD_BITS-1:0] ny;
		acc = '0;
		for (int dy = -1; dy <= 1; dy++) begin
			for (int dx = -1; dx <= 1; dx++) begin
				nx = x + COORD_BITS'(dx);
				ny = y + COORD_BITS'(dy);
				if (dx == 0 && dy == 0)
					acc += 12'(CENTRE_WEIGHT) * 12'(tile_model[{f, ny, nx}]);
				else
					acc += 12'(tile_model[{f, ny, nx}]);
			end
		end
		return 8'(acc / WEIGHT_TOTAL);
	endfunction

	// True when all nine entries around (f, x, y) will have been written.
	function automatic bit patch_filled(input logic [FRAME_BITS-1:0] f,
			input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
		logic [COORD_BITS-1:0] nx;
		logic [COORD_BITS-1:0] ny;
		for (int dy = -1; dy <= 1; dy++) begin
			for (int dx = -1; dx <= 1; dx++) begin
				nx = x + COORD_BITS'(dx);
				ny = y + COORD_BITS'(dy);
				if (!gen_filled[{f, ny, nx}])
					return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	task automatic flag_mismatch(input string what, input string want_txt,
			input logic [7:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t ns: %s: expected %s, got %0d", $time, what, want_txt, got);
	endtask

	// Append one word to the pending list. The idle rate cycles through phases:
	// none, heavy (47%), none, light (12%).
	task automatic push_op(input logic act, input logic [FRAME_BITS-1:0] f,
			input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
			input logic [SAMPLE_IN_W-1:0] v);
		tile_op_t    op;
		int unsigned phase_gap[4];
		phase_gap = '{0, 47, 0, 12};
		op.act        = act;
		op.frame      = f;
		op.x          = x;
		op.y          = y;
		op.value      = v;
		op.gap_pct    = phase_gap[(pending_ops.size() / PHASE_LEN) % 4];
		op.wait_drain = hold_for_drain;
		hold_for_drain = 1'b0;
		if (act == ACT_WRITE)
			gen_filled[{f, y, x}] = 1'b1;
		pending_ops.push_back(op);
	endtask

	// Write the first n_cells of the 3x3 patch around (cx, cy) in shuffled
	// order; a negative fill means random samples. Read back the center when
	// read_back is set and the patch ends up complete.
	task automatic queue_patch(input logic [FRAME_BITS-1:0] f,
			input logic [COORD_BITS-1:0] cx, input logic [COORD_BITS-1:0] cy,
			input int fill, input int n_cells, input bit read_back);
		int                    ord[9];
		int                    j;
		int                    tmp;
		logic [COORD_BITS-1:0] nx;
		logic [COORD_BITS-1:0] ny;
		for (int i = 0; i < 9; i++)
			ord[i] = i;
		for (int i = 8; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = ord[i];
			ord[i] = ord[j];
			ord[j] = tmp;
		end
		for (int k = 0; k < n_cells; k++) begin
			nx = cx + COORD_BITS'(ord[k] % 3 - 1);
			ny = cy + COORD_BITS'(ord[k] / 3 - 1);
			push_op(ACT_WRITE, f, nx, ny,
				(fill < 0) ? SAMPLE_IN_W'($urandom_range(255)) : SAMPLE_IN_W'(fill));
		end
		if (read_back && patch_filled(f, cx, cy)) begin
			ready_centers.push_back({f, cy, cx});
			push_op(ACT_READ, f, cx, cy, SAMPLE_IN_W'($urandom_range(255)));
		end
	endtask

	task automatic build_stimulus();
		int          base_count;
		int          pick;
		logic [13:0] c;
		logic [1:0]  f;
		logic [5:0]  x;
		logic [5:0]  y;

		// Directed: full-scale patch at the origin corner of the last frame,
		// all-zero patch at the far corner of frame 0, then bump its center
		// and a diagonal neighbor to full scale. Both corners exercise wrap.
		queue_patch(2'd3, 6'd0, 6'd0, 255, 9, 1'b1);
		queue_patch(2'd0, 6'd63, 6'd63, 0, 9, 1'b1);
		push_op(ACT_WRITE, 2'd0, 6'd63, 6'd63, 8'd255);
		push_op(ACT_READ, 2'd0, 6'd63, 6'd63, 8'd0);
		push_op(ACT_WRITE, 2'd0, 6'd62, 6'd62, 8'd255);
		push_op(ACT_READ, 2'd0, 6'd63, 6'd63, 8'd255);

		// Random: mostly complete patches with random content, plus re-reads
		// of known patches, broken patches and stray writes.
		hold_for_drain = 1'b1;
		base_count = pending_ops.size();
		while (pending_ops.size() < base_count + RANDOM_OPS) begin
			if (pending_ops.size() - base_count >= RANDOM_OPS / 2 &&
					pending_ops.size() - base_count < RANDOM_OPS / 2 + 10)
				hold_for_drain = 1'b1;
			pick = $urandom_range(99);
			f = 2'($urandom_range(3));
			x = 6'($urandom_range(63));
			y = 6'($urandom_range(63));
			if (pick < 55) begin
				queue_patch(f, x, y, -1, 9, 1'b1);
			end else if (pick < 80 && ready_centers.size() > 0) begin
				c = ready_centers[$urandom_range(ready_centers.size() - 1)];
				push_op(ACT_READ, c[13:12], c[5:0], c[11:6],
					SAMPLE_IN_W'($urandom_range(255)));
			end else if (pick < 90) begin
				queue_patch(f, x, y, -1, $urandom_range(1, 8), 1'b1);
			end else begin
				push_op(ACT_WRITE, f, x, y, SAMPLE_IN_W'($urandom_range(255)));
				if (patch_filled(f, x, y))
					push_op(ACT_READ, f, x, y, SAMPLE_IN_W'($urandom_range(255)));
			end
		end
	endtask

	// Driver: hold the word while busy, update the shadow tiles and the
	// expected reads on each accepting edge, then launch the next word or idle.
	always @(posedge clk) begin : drive_words
		tile_op_t op;
		if (!arst_n) begin
			start       <= 1'b0;
			action      <= ACT_WRITE;
			frame_index <= '0;
			column      <= '0;
			row         <= '0;
			sample      <= '0;
		end else if (!(start && busy)) begin
			if (start) begin
				if (action == ACT_READ)
					expected_smoothed.push_back(smoothed_at(frame_index, column, row));
				else
					tile_model[{frame_index, row, column}] = sample;
			end
			if (pending_ops.size() > 0 &&
					(!pending_ops[0].wait_drain || expected_smoothed.size() == 0) &&
					$urandom_range(99) >= pending_ops[0].gap_pct) begin
				op = pending_ops.pop_front();
				start       <= 1'b1;
				action      <= op.act;
				frame_index <= op.frame;
				column      <= op.x;
				row         <= op.y;
				sample      <= op.value;
			end else begin
				// Idle: drop start and scramble the fields, which must be ignored.
				start       <= 1'b0;
				action      <= 1'($urandom_range(1));
				frame_index <= FRAME_BITS'($urandom_range(3));
				column      <= COORD_BITS'($urandom_range(63));
				row         <= COORD_BITS'($urandom_range(63));
				sample      <= SAMPLE_IN_W'($urandom_range(255));
			end
		end
	end

	// Monitor: every done strobe must match the oldest outstanding read.
	always @(posedge clk) begin : check_results
		logic [7:0] want;
		if (arst_n && done) begin
			if (expected_smoothed.size() == 0) begin
				flag_mismatch("smoothed word with no read outstanding", "none", smoothed);
			end else begin
				want = expected_smoothed.pop_front();
				if (smoothed !== want)
					flag_mismatch("smoothed", $sformatf("%0d", want), smoothed);
			end
		end
	end

	initial begin
		mismatch_count = 0;
		hold_for_drain = 1'b0;
		build_stimulus();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Advance until every word is taken and every read has returned,
		// then let the pipe settle so a stray strobe still gets caught.
		do
			@(negedge clk);
		while (pending_ops.size() != 0 || start);
		while (expected_smoothed.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
		if (mismatch_count == 0)
			$display("toroidal_tile_smoothing_filter regression: pass");
		else
			$display("toroidal_tile_smoothing_filter regression: fail");
		$finish;
	end

	// Watchdog: reports a failure and ends the run if it has not finished in time.
	initial begin
		#2000000;
		$display("toroidal_tile_smoothing_filter regression: fail");
		$finish;
	end

endmodule
